// ===== rtl/gns_pkg.sv =====
package gns_pkg;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int CODE_W = 2;
    localparam int CNT_W  = 4;
    localparam int PCT_W  = 7;
    localparam int DIM_W  = 7;
    localparam int STEP_W = 4;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int PROD_W = 11;

    localparam logic [PCT_W-1:0] THR_RST  = 7'd35;
    localparam logic [DIM_W-1:0] ROWS_RST = 7'd40;
    localparam logic [DIM_W-1:0] COLS_RST = 7'd60;

    localparam logic [PROD_W-1:0] PCT_SCALE = 11'd100;
    localparam int                DIM_MIN   = 2;
    localparam logic [CNT_W-1:0]  NB_MIN    = 4'd3;
    localparam logic [CNT_W-1:0]  NB_MAX    = 4'd8;

    // step 0 reads the centre, steps 1..8 the neighbours
    localparam logic [STEP_W-1:0] STEP_CENTRE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_END    = 4'd9;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_ROWS      = 2'd1;
    localparam logic [1:0] REG_COLS      = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CODE_W-1:0] CODE_EMPTY = 2'd0;

    // row offset for a step, two's complement
    function automatic logic [1:0] f_dr(input logic [STEP_W-1:0] s);
        logic [1:0] d;
        case (s)
            4'd1, 4'd2, 4'd3: d = 2'b11;
            4'd6, 4'd7, 4'd8: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

    // column offset for a step, two's complement
    function automatic logic [1:0] f_dc(input logic [STEP_W-1:0] s);
        logic [1:0] d;
        case (s)
            4'd1, 4'd4, 4'd6: d = 2'b11;
            4'd3, 4'd5, 4'd8: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/gns_in_if.sv =====
interface gns_in_if import gns_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CODE_W-1:0] cell_code;

    modport source(output valid, kind, row, col, cell_code, input ready);
    modport sink(input valid, kind, row, col, cell_code, output ready);
endinterface

// ===== rtl/gns_out_if.sv =====
interface gns_out_if import gns_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             out_of_range;
    logic [CNT_W-1:0] neighbour_count;
    logic [CNT_W-1:0] same_count;
    logic             satisfied;
    logic             wants_move;

    modport source(output valid, out_of_range, neighbour_count, same_count, satisfied,
                   wants_move, input ready);
    modport sink(input valid, out_of_range, neighbour_count, same_count, satisfied,
                 wants_move, output ready);
endinterface

// ===== rtl/gns_ram.sv =====
module gns_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/grid_neighbour_satisfaction_core.sv =====
// Query: reads in S_RD, then S_DONE loads the output register; the nine grid reads
// (centre plus eight neighbours) share the single grid memory port, one per cycle.
// Write: S_WR, then S_DONE loads the output register. One item in flight at a time; the
// next item is accepted once the result sits in the output register.
// Reset (i_rst_n low, synchronous) clears control state and loads register defaults;
// grid contents are undefined until written.
module grid_neighbour_satisfaction_core
    import gns_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gns_in_if.sink            i_in,
    gns_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int RW    = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int DWR   = $clog2(MAX_ROWS + 1);
    localparam int DWC   = $clog2(MAX_COLS + 1);
    localparam int DWM   = (DWR > DWC) ? DWR : DWC;
    localparam int DW    = (DWM > DIM_W) ? DWM : DIM_W;
    localparam int XW    = ROW_W + 1;

    localparam logic [DW-1:0] LP_MAX_R = DW'(MAX_ROWS);
    localparam logic [DW-1:0] LP_MAX_C = DW'(MAX_COLS);
    localparam logic [DW-1:0] LP_MIN   = DW'(DIM_MIN);

    typedef enum logic [1:0] {S_IDLE, S_WR, S_RD, S_DONE} t_state;

    // configuration registers
    logic [PCT_W-1:0] r_thr;
    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RST;
            r_rows <= ROWS_RST;
            r_cols <= COLS_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_THRESHOLD: r_thr  <= pwdata[PCT_W-1:0];
                REG_ROWS:      r_rows <= pwdata[DIM_W-1:0];
                REG_COLS:      r_cols <= pwdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = APB_DW'(r_thr);
            REG_ROWS:      prdata = APB_DW'(r_rows);
            REG_COLS:      prdata = APB_DW'(r_cols);
            default:       prdata = '0;
        endcase
    end

    // clamped grid dimensions
    logic [DW-1:0] w_rows_x, w_cols_x, w_nr, w_nc;

    assign w_rows_x = DW'(r_rows);
    assign w_cols_x = DW'(r_cols);
    assign w_nr = (w_rows_x < LP_MIN) ? LP_MIN : ((w_rows_x > LP_MAX_R) ? LP_MAX_R : w_rows_x);
    assign w_nc = (w_cols_x < LP_MIN) ? LP_MIN : ((w_cols_x > LP_MAX_C) ? LP_MAX_C : w_cols_x);

    // sequencer state
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_kind, n_kind;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_pend, n_pend;
    logic              r_pend_ctr, n_pend_ctr;
    logic              r_pend_nb, n_pend_nb;
    logic [CODE_W-1:0] r_centre, n_centre;
    logic [CNT_W-1:0]  r_neigh, n_neigh;
    logic [CNT_W-1:0]  r_same, n_same;
    logic              r_ovld, n_ovld;
    logic              r_o_oor, n_o_oor;
    logic [CNT_W-1:0]  r_o_neigh, n_o_neigh;
    logic [CNT_W-1:0]  r_o_same, n_o_same;
    logic              r_o_sat, n_o_sat;
    logic              r_o_move, n_o_move;

    // address of the current step
    logic [1:0]        w_dr, w_dc;
    logic [XW-1:0]     w_r, w_c;
    logic [RW+XW-1:0]  w_r_ext;
    logic [CW+XW-1:0]  w_c_ext;
    logic [AW-1:0]     w_addr;
    logic              w_inb, w_oor, w_we;
    logic [CODE_W-1:0] w_rdata;

    assign w_dr    = f_dr(r_step);
    assign w_dc    = f_dc(r_step);
    assign w_r     = {1'b0, r_row} + {{(XW-2){w_dr[1]}}, w_dr};
    assign w_c     = {1'b0, r_col} + {{(XW-2){w_dc[1]}}, w_dc};
    assign w_r_ext = {{RW{1'b0}}, w_r};
    assign w_c_ext = {{CW{1'b0}}, w_c};
    assign w_addr  = {w_r_ext[RW-1:0], w_c_ext[CW-1:0]};
    assign w_inb   = (DW'(w_r) < w_nr) && (DW'(w_c) < w_nc);
    assign w_oor   = (DW'(r_row) >= w_nr) || (DW'(r_col) >= w_nc);
    assign w_we    = (r_state == S_WR) && !w_oor;

    gns_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_code),
        .o_rdata (w_rdata)
    );

    // satisfaction test
    logic [PROD_W-1:0] w_lhs, w_rhs;
    logic              w_sat, w_query;

    assign w_lhs   = PROD_W'(r_same) * PCT_SCALE;
    assign w_rhs   = PROD_W'(r_thr) * PROD_W'(r_neigh);
    assign w_sat   = (w_lhs >= w_rhs);
    assign w_query = (r_kind == KIND_QUERY) && !w_oor;

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_ovld;
    assign o_out.out_of_range    = r_o_oor;
    assign o_out.neighbour_count = r_o_neigh;
    assign o_out.same_count      = r_o_same;
    assign o_out.satisfied       = r_o_sat;
    assign o_out.wants_move      = r_o_move;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_kind     = r_kind;
        n_row      = r_row;
        n_col      = r_col;
        n_code     = r_code;
        n_pend     = 1'b0;
        n_pend_ctr = 1'b0;
        n_pend_nb  = 1'b0;
        n_centre   = r_centre;
        n_neigh    = r_neigh;
        n_same     = r_same;
        n_ovld     = r_ovld && !o_out.ready;
        n_o_oor    = r_o_oor;
        n_o_neigh  = r_o_neigh;
        n_o_same   = r_o_same;
        n_o_sat    = r_o_sat;
        n_o_move   = r_o_move;

        // returning read data
        if (r_pend) begin
            if (r_pend_ctr) begin
                n_centre = w_rdata;
            end
            if (r_pend_nb) begin
                n_neigh = r_neigh + CNT_W'(1);
                n_same  = r_same + CNT_W'(w_rdata == r_centre);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind  = i_in.kind;
                    n_row   = i_in.row;
                    n_col   = i_in.col;
                    n_code  = i_in.cell_code;
                    n_step  = STEP_CENTRE;
                    n_neigh = '0;
                    n_same  = '0;
                    n_state = (i_in.kind == KIND_WRITE) ? S_WR : S_RD;
                end
            end
            S_WR: begin
                n_state = S_DONE;
            end
            S_RD: begin
                if (w_oor || r_step == STEP_END) begin
                    n_state = S_DONE;
                end else begin
                    n_pend     = 1'b1;
                    n_pend_ctr = (r_step == STEP_CENTRE);
                    n_pend_nb  = (r_step != STEP_CENTRE) && w_inb;
                    n_step     = r_step + STEP_W'(1);
                end
            end
            S_DONE: begin
                if (!r_ovld || o_out.ready) begin
                    n_ovld    = 1'b1;
                    n_o_oor   = w_oor;
                    n_o_neigh = w_query ? r_neigh : '0;
                    n_o_same  = w_query ? r_same : '0;
                    n_o_sat   = w_query && w_sat;
                    n_o_move  = w_query && !w_sat && (r_centre != CODE_EMPTY);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= STEP_CENTRE;
            r_pend     <= 1'b0;
            r_pend_ctr <= 1'b0;
            r_pend_nb  <= 1'b0;
            r_neigh    <= '0;
            r_same     <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_pend     <= n_pend;
            r_pend_ctr <= n_pend_ctr;
            r_pend_nb  <= n_pend_nb;
            r_neigh    <= n_neigh;
            r_same     <= n_same;
            r_ovld     <= n_ovld;
        end
        r_kind    <= n_kind;
        r_row     <= n_row;
        r_col     <= n_col;
        r_code    <= n_code;
        r_centre  <= n_centre;
        r_o_oor   <= n_o_oor;
        r_o_neigh <= n_o_neigh;
        r_o_same  <= n_o_same;
        r_o_sat   <= n_o_sat;
        r_o_move  <= n_o_move;
    end

    a_same_le_neigh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_same <= r_neigh) && (r_neigh <= NB_MAX))
        else $error("same count exceeds neighbour count");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> !w_we)
        else $error("grid write during neighbour reads");

    a_min_neigh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_kind == KIND_QUERY && !w_oor) |-> (r_neigh >= NB_MIN))
        else $error("in-range query with too few neighbours");

    a_pend_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == S_RD))
        else $error("read pending outside read phase");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD && r_step == STEP_LAST && !w_oor) |=> (r_step == STEP_END))
        else $error("step counter overran");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import gns_pkg::*;
;

    localparam int MAX_ROWS        = 64;
    localparam int MAX_COLS        = 64;
    localparam int NUM_PHASES      = 13;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int CYCLE_LIMIT     = 5_000_000;

    typedef struct packed {
        logic              kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CODE_W-1:0] code;
    } grid_op_t;

    typedef struct {
        grid_op_t op;
        bit       after_drain;
    } queued_op_t;

    typedef struct packed {
        logic             oor;
        logic [CNT_W-1:0] neighbours;
        logic [CNT_W-1:0] same;
        logic             satisfied;
        logic             move;
    } sat_verdict_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    gns_in_if  op_bus();
    gns_out_if verdict_bus();

    grid_neighbour_satisfaction_core #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_bus),
        .o_out   (verdict_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // settings as seen by the predictor and the generator
    logic [PCT_W-1:0] thr_setting  = THR_RST;
    logic [DIM_W-1:0] rows_setting = ROWS_RST;
    logic [DIM_W-1:0] cols_setting = COLS_RST;

    logic [CODE_W-1:0] grid_model [MAX_ROWS*MAX_COLS];
    bit                cell_known [MAX_ROWS*MAX_COLS];

    queued_op_t   ops_to_send[$];
    sat_verdict_t verdicts_due[$];

    int gen_count;
    int mismatch_count;
    int verdicts_checked;
    int send_gap;
    int hold_left;
    int cycle_count;
    bit long_hold_done;
    bit no_idle;

    function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic int rows_now();
        return clamp_dim(rows_setting, MAX_ROWS);
    endfunction

    function automatic int cols_now();
        return clamp_dim(cols_setting, MAX_COLS);
    endfunction

    function automatic sat_verdict_t predict_verdict(grid_op_t op);
        sat_verdict_t v;
        int nr, nc, rr, cc, nb, same;
        logic [CODE_W-1:0] centre;
        nr = rows_now();
        nc = cols_now();
        v = '0;
        v.oor = (int'(op.row) >= nr) || (int'(op.col) >= nc);
        if (v.oor) return v;
        if (op.kind == KIND_WRITE) begin
            grid_model[int'(op.row) * MAX_COLS + int'(op.col)] = op.code;
            return v;
        end
        centre = grid_model[int'(op.row) * MAX_COLS + int'(op.col)];
        nb = 0;
        same = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = int'(op.row) + dr;
                cc = int'(op.col) + dc;
                if (dr == 0 && dc == 0) continue;
                if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) continue;
                nb++;
                if (grid_model[rr * MAX_COLS + cc] == centre) same++;
            end
        end
        v.neighbours = CNT_W'(nb);
        v.same = CNT_W'(same);
        v.satisfied = (int'(PCT_SCALE) * same >= int'(thr_setting) * nb);
        v.move = (centre != CODE_EMPTY) && !v.satisfied;
        return v;
    endfunction

    // --- stimulus generation ---

    function automatic void queue_op(logic kind, int r, int c, int code);
        queued_op_t q;
        q.op.kind = kind;
        q.op.row = ROW_W'(r);
        q.op.col = COL_W'(c);
        q.op.code = CODE_W'(code);
        // now and then the sender waits for every outstanding result
        q.after_drain = (gen_count % 101 == 100);
        ops_to_send.push_back(q);
        gen_count++;
        if (kind == KIND_WRITE && r < rows_now() && c < cols_now())
            cell_known[r * MAX_COLS + c] = 1'b1;
    endfunction

    function automatic bit query_safe(int r, int c);
        int rr, cc;
        if (r >= rows_now() || c >= cols_now()) return 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if (rr < 0 || cc < 0 || rr >= rows_now() || cc >= cols_now()) continue;
                if (!cell_known[rr * MAX_COLS + cc]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int pick_coord(int n);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    // writes the unknown part of a neighbourhood (sometimes all of it), then queries
    function automatic void queue_neighbourhood_query(int r, int c);
        bit uniform;
        int ucode, rr, cc;
        uniform = ($urandom_range(0, 4) == 0);
        ucode = $urandom_range(0, 3);
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if (rr < 0 || cc < 0 || rr >= rows_now() || cc >= cols_now()) continue;
                if (uniform)
                    queue_op(KIND_WRITE, rr, cc, ucode);
                else if (!cell_known[rr * MAX_COLS + cc] || $urandom_range(0, 5) == 0)
                    queue_op(KIND_WRITE, rr, cc, $urandom_range(0, 3));
            end
        end
        queue_op(KIND_QUERY, r, c, $urandom_range(0, 3));
    endfunction

    function automatic void queue_random_sequence();
        int pick, r, c, nr, nc;
        logic kind;
        nr = rows_now();
        nc = cols_now();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            queue_neighbourhood_query(pick_coord(nr), pick_coord(nc));
        end else if (pick < 78) begin
            queue_op(KIND_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                     $urandom_range(0, 3));
        end else begin
            r = $urandom_range(0, MAX_ROWS - 1);
            c = $urandom_range(0, MAX_COLS - 1);
            if (pick < 90) begin
                if (nr < MAX_ROWS && (nc == MAX_COLS || $urandom_range(0, 1) == 1))
                    r = $urandom_range(nr, MAX_ROWS - 1);
                else if (nc < MAX_COLS)
                    c = $urandom_range(nc, MAX_COLS - 1);
            end
            kind = query_safe(r, c) ? logic'($urandom_range(0, 1)) : KIND_WRITE;
            queue_op(kind, r, c, $urandom_range(0, 3));
        end
    endfunction

    function automatic int pick_send_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 45) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // --- configuration and sequencing ---

    task automatic apb_write(logic [1:0] idx, logic [DIM_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_setting  = val;
            REG_ROWS:      rows_setting = val;
            REG_COLS:      cols_setting = val;
            default: ;
        endcase
    endtask

    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (ops_to_send.size() != 0 || op_bus.valid || verdicts_due.size() != 0);
    endtask

    initial begin
        int phase, phase_end, thr, rows, cols;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        op_bus.valid = 1'b0;
        op_bus.kind = KIND_WRITE;
        op_bus.row = '0;
        op_bus.col = '0;
        op_bus.cell_code = '0;
        verdict_bus.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 3x3 block at the origin under the reset settings (35%, 40 x 60)
        queue_op(KIND_WRITE, 0, 0, 3);
        queue_op(KIND_WRITE, 0, 1, 3);
        queue_op(KIND_WRITE, 0, 2, 1);
        queue_op(KIND_WRITE, 1, 0, 2);
        queue_op(KIND_WRITE, 1, 1, 0);
        queue_op(KIND_WRITE, 1, 2, 0);
        queue_op(KIND_WRITE, 2, 0, 1);
        queue_op(KIND_WRITE, 2, 1, 2);
        queue_op(KIND_WRITE, 2, 2, 0);
        queue_op(KIND_QUERY, 0, 0, 3);      // corner, code 3 centre
        queue_op(KIND_QUERY, 0, 1, 0);      // edge
        queue_op(KIND_QUERY, 1, 1, 2);      // interior, empty centre
        queue_op(KIND_QUERY, 1, 0, 1);      // edge
        queue_op(KIND_WRITE, 1, 1, 2);
        queue_op(KIND_QUERY, 1, 1, 3);
        queue_op(KIND_WRITE, 40, 0, 1);     // out of range, store unchanged
        queue_op(KIND_WRITE, 0, 60, 2);
        queue_op(KIND_WRITE, 63, 63, 3);
        queue_op(KIND_QUERY, 39, 60, 1);
        queue_op(KIND_QUERY, 63, 63, 2);
        queue_op(KIND_QUERY, 40, 59, 0);
        wait_until_drained();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin thr = 0;   rows = 64;  cols = 64; end
                1: begin thr = 100; rows = 2;   cols = 2;  end
                2: begin thr = 127; rows = 0;   cols = 1;  end
                3: begin thr = 101; rows = 127; cols = 65; end
                4: begin thr = 50;  rows = 3;   cols = 64; end
                5: begin thr = 67;  rows = 64;  cols = 3;  end
                6: begin thr = 35;  rows = 64;  cols = 64; end
                default: begin
                    thr = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                                      : $urandom_range(0, 100);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: rows = $urandom_range(2, 8);
                        6, 7:             rows = $urandom_range(9, 64);
                        8:                rows = $urandom_range(0, 1);
                        default:          rows = $urandom_range(65, 127);
                    endcase
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: cols = $urandom_range(2, 8);
                        6, 7:             cols = $urandom_range(9, 64);
                        8:                cols = $urandom_range(0, 1);
                        default:          cols = $urandom_range(65, 127);
                    endcase
                end
            endcase
            apb_write(REG_THRESHOLD, DIM_W'(thr));
            apb_write(REG_ROWS, DIM_W'(rows));
            apb_write(REG_COLS, DIM_W'(cols));
            no_idle = (phase % 4 == 3);
            phase_end = gen_count + ITEMS_PER_PHASE;
            while (gen_count < phase_end) queue_random_sequence();
            wait_until_drained();
        end

        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0 && verdicts_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // --- driver ---

    always @(posedge i_clk) begin
        grid_op_t   seen;
        queued_op_t nxt;
        if (!i_rst_n) begin
            op_bus.valid <= 1'b0;
        end else begin
            if (op_bus.valid && op_bus.ready) begin
                seen.kind = op_bus.kind;
                seen.row  = op_bus.row;
                seen.col  = op_bus.col;
                seen.code = op_bus.cell_code;
                verdicts_due.push_back(predict_verdict(seen));
            end
            if (!op_bus.valid || op_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    op_bus.valid <= 1'b0;
                end else if (ops_to_send.size() > 0 &&
                             !(ops_to_send[0].after_drain && verdicts_due.size() != 0)) begin
                    nxt = ops_to_send.pop_front();
                    op_bus.valid     <= 1'b1;
                    op_bus.kind      <= nxt.op.kind;
                    op_bus.row       <= nxt.op.row;
                    op_bus.col       <= nxt.op.col;
                    op_bus.cell_code <= nxt.op.code;
                    send_gap = pick_send_gap();
                end else begin
                    op_bus.valid <= 1'b0;
                end
            end
        end
    end

    // --- receiver back-pressure ---

    always @(posedge i_clk) begin
        int pick;
        if (!i_rst_n) begin
            verdict_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            verdict_bus.ready <= 1'b0;
        end else if (!long_hold_done && verdicts_checked >= 150) begin
            // long stall so the core backs up into its input
            long_hold_done = 1'b1;
            hold_left = 399;
            verdict_bus.ready <= 1'b0;
        end else if (no_idle) begin
            verdict_bus.ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 999);
            if (pick < 650) begin
                verdict_bus.ready <= 1'b1;
            end else begin
                if (pick < 950)      hold_left = $urandom_range(0, 2);
                else if (pick < 997) hold_left = $urandom_range(3, 15);
                else                 hold_left = $urandom_range(60, 250);
                verdict_bus.ready <= 1'b0;
            end
        end
    end

    // --- monitor / checker ---

    task automatic report_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %0s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        sat_verdict_t want;
        if (i_rst_n && verdict_bus.valid && verdict_bus.ready) begin
            verdicts_checked++;
            if (verdicts_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result transaction with nothing expected", $realtime);
            end else begin
                want = verdicts_due.pop_front();
                if (verdict_bus.out_of_range !== want.oor)
                    report_mismatch("out_of_range", int'(want.oor),
                                    int'(verdict_bus.out_of_range));
                if (verdict_bus.neighbour_count !== want.neighbours)
                    report_mismatch("neighbour_count", int'(want.neighbours),
                                    int'(verdict_bus.neighbour_count));
                if (verdict_bus.same_count !== want.same)
                    report_mismatch("same_count", int'(want.same),
                                    int'(verdict_bus.same_count));
                if (verdict_bus.satisfied !== want.satisfied)
                    report_mismatch("satisfied", int'(want.satisfied),
                                    int'(verdict_bus.satisfied));
                if (verdict_bus.wants_move !== want.move)
                    report_mismatch("wants_move", int'(want.move),
                                    int'(verdict_bus.wants_move));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/gns_pkg.sv
rtl/gns_in_if.sv
rtl/gns_out_if.sv
rtl/gns_ram.sv
rtl/grid_neighbour_satisfaction_core.sv
verif/testbench.sv
